// ----- hw/rtl/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, constants and round functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueAw    = $clog2(QueueDepth);

   typedef logic [WordWidth-1:0] word_type;

   typedef struct packed {
      logic     last;
      word_type word;
   } qentry_type;

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PadByte = 8'h80;

   function automatic word_type rotr(input word_type v, input int unsigned n);
      rotr = (v >> n) | (v << (WordWidth - n));
   endfunction

   function automatic word_type ssig0(input word_type x);
      ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type ssig1(input word_type x);
      ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type bsig0(input word_type x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type bsig1(input word_type x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sha_front.sv -----
// ----------------------------------------------------------------------------
// SHA-256 front end
// Packs message bytes into big-endian words, counts the message length and
// generates the padding and length words when a message is finished.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_kind,
   input  wire logic [7:0]         req_data_byte,
   output logic                    push,
   output sha_pkg::qentry_type     push_entry,
   input  wire logic               full
);
   import sha_pkg::*;

   typedef enum logic [1:0] {
      FR_IDLE = 2'b01,
      FR_PAD  = 2'b10
   } fstate_type;

   fstate_type  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [23:0] acc_ff, acc_in;
   logic [3:0]  idx_ff, idx_in;
   logic        first_ff, first_in;
   logic        extra_ff, extra_in;
   logic        take;
   word_type    pad_word;

   assign req_ready = (state_ff == FR_IDLE) && !full;
   assign take      = req_valid && req_ready;

   always_comb begin
      case (fill_ff[1:0])
         2'd0:    pad_word = {PadByte, 24'h0};
         2'd1:    pad_word = {acc_ff[7:0], PadByte, 16'h0};
         2'd2:    pad_word = {acc_ff[15:0], PadByte, 8'h0};
         default: pad_word = {acc_ff[23:0], PadByte};
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      acc_in     = acc_ff;
      idx_in     = idx_ff;
      first_in   = first_ff;
      extra_in   = extra_ff;
      push       = 1'b0;
      push_entry = '0;
      case (state_ff)
         FR_IDLE: begin
            if (take) begin
               if (!req_kind) begin
                  acc_in  = {acc_ff[15:0], req_data_byte};
                  fill_in = fill_ff + 6'd1;
                  bits_in = bits_ff + 64'd8;
                  if (fill_ff[1:0] == 2'd3) begin
                     push       = 1'b1;
                     push_entry = '{last: 1'b0, word: {acc_ff, req_data_byte}};
                  end
               end else begin
                  state_in = FR_PAD;
                  idx_in   = fill_ff[5:2];
                  first_in = 1'b1;
                  extra_in = (fill_ff[5:2] >= 4'd14);
               end
            end
         end
         FR_PAD: begin
            if (!full) begin
               push = 1'b1;
               if (first_ff) begin
                  push_entry.word = pad_word;
               end else if (!extra_ff && idx_ff == 4'd14) begin
                  push_entry.word = bits_ff[63:32];
               end else if (!extra_ff && idx_ff == 4'd15) begin
                  push_entry.word = bits_ff[31:0];
                  push_entry.last = 1'b1;
               end else begin
                  push_entry.word = '0;
               end
               first_in = 1'b0;
               idx_in   = idx_ff + 4'd1;
               if (idx_ff == 4'd15) begin
                  extra_in = 1'b0;
               end
               if (push_entry.last) begin
                  state_in = FR_IDLE;
                  fill_in  = '0;
                  bits_in  = '0;
               end
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
         first_ff <= 1'b0;
         extra_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         first_ff <= first_in;
         extra_ff <= extra_in;
         idx_ff   <= idx_in;
      end
      acc_ff <= acc_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/sha_queue.sv -----
// ----------------------------------------------------------------------------
// SHA-256 word queue
// A short first-in first-out buffer of message words between the two halves.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire sha_pkg::qentry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output sha_pkg::qentry_type      pop_entry,
   output logic                     empty
);
   import sha_pkg::*;

   qentry_type         mem_ff [QueueDepth];
   logic [QueueAw-1:0] wr_ff, rd_ff;
   logic [QueueAw:0]   cnt_ff;

   assign full      = (cnt_ff == (QueueAw+1)'(QueueDepth));
   assign empty     = (cnt_ff == '0);
   assign pop_entry = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/sha_back.sv -----
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Collects sixteen words, runs 64 rounds, updates the chaining state and,
// after the last block of a message, presents the digest one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_back (
   input  wire logic                clock,
   input  wire logic                reset,
   output logic                     pop,
   input  wire sha_pkg::qentry_type pop_entry,
   input  wire logic                empty,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [31:0]              rsp_digest_word,
   output logic [2:0]               rsp_word_index,
   output logic                     rsp_last_word
);
   import sha_pkg::*;

   typedef enum logic [3:0] {
      BK_LOAD  = 4'b0001,
      BK_ROUND = 4'b0010,
      BK_SUM   = 4'b0100,
      BK_OUT   = 4'b1000
   } bstate_type;

   bstate_type state_ff;
   word_type   w_ff [16];
   word_type   r_ff [8];
   word_type   h_ff [8];
   logic [3:0] cnt_ff;
   logic [5:0] t_ff;
   logic [2:0] oidx_ff;
   logic       last_ff;
   word_type   w_new, t1, t2;

   assign pop             = (state_ff == BK_LOAD) && !empty;
   assign rsp_valid       = (state_ff == BK_OUT);
   assign rsp_digest_word = h_ff[oidx_ff];
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = (oidx_ff == 3'd7);

   assign w_new = w_ff[0] + ssig0(w_ff[1]) + w_ff[9] + ssig1(w_ff[14]);
   assign t1 = r_ff[7] + bsig1(r_ff[4]) + ((r_ff[4] & r_ff[5]) ^ (~r_ff[4] & r_ff[6]))
               + RoundK[t_ff] + w_ff[0];
   assign t2 = bsig0(r_ff[0])
               + ((r_ff[0] & r_ff[1]) ^ (r_ff[0] & r_ff[2]) ^ (r_ff[1] & r_ff[2]));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_LOAD;
         cnt_ff   <= '0;
         t_ff     <= '0;
         oidx_ff  <= '0;
         last_ff  <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= InitHash[i];
         end
      end else begin
         case (state_ff)
            BK_LOAD: begin
               if (pop) begin
                  cnt_ff <= cnt_ff + 4'd1;
                  if (cnt_ff == 4'd15) begin
                     last_ff  <= pop_entry.last;
                     t_ff     <= '0;
                     state_ff <= BK_ROUND;
                  end
               end
            end
            BK_ROUND: begin
               t_ff <= t_ff + 6'd1;
               if (t_ff == 6'd63) begin
                  state_ff <= BK_SUM;
               end
            end
            BK_SUM: begin
               for (int i = 0; i < 8; i++) begin
                  h_ff[i] <= h_ff[i] + r_ff[i];
               end
               oidx_ff  <= '0;
               state_ff <= last_ff ? BK_OUT : BK_LOAD;
            end
            BK_OUT: begin
               if (rsp_ready) begin
                  oidx_ff <= oidx_ff + 3'd1;
                  if (oidx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) begin
                        h_ff[i] <= InitHash[i];
                     end
                     state_ff <= BK_LOAD;
                  end
               end
            end
            default: begin
               state_ff <= BK_LOAD;
            end
         endcase
      end
      if (pop) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= pop_entry.word;
         if (cnt_ff == 4'd15) begin
            for (int i = 0; i < 8; i++) begin
               r_ff[i] <= h_ff[i];
            end
         end
      end else if (state_ff == BK_ROUND) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= w_new;
         r_ff[7]  <= r_ff[6];
         r_ff[6]  <= r_ff[5];
         r_ff[5]  <= r_ff[4];
         r_ff[4]  <= r_ff[3] + t1;
         r_ff[3]  <= r_ff[2];
         r_ff[2]  <= r_ff[1];
         r_ff[1]  <= r_ff[0];
         r_ff[0]  <= t1 + t2;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/sha256_stream_hasher_top.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the eight digest words on finish.
//
//   Channel   Direction  Carries
//   req_      in         kind, data_byte (one byte or a finish request)
//   rsp_      out        digest_word, word_index, last_word
//
// A data byte is taken while the front is idle and the word queue has room.
// The engine loads the sixteen words of a 64-byte block, runs 64 rounds and
// updates the state before it takes the next block; this sets the sustained rate.
// A finish request holds off new requests until all padding words are queued.
// Reset is synchronous and restores the initial hash state.
// A stalled response holds the engine; the front keeps filling the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);
   import sha_pkg::*;

   logic       push, full, pop, empty;
   qentry_type push_entry, pop_entry;

   sha_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_data_byte,
      .push, .push_entry, .full
   );

   sha_queue u_queue (
      .clock, .reset, .push, .push_entry, .full, .pop, .pop_entry, .empty
   );

   sha_back u_back (
      .clock, .reset, .pop, .pop_entry, .empty, .rsp_valid, .rsp_ready,
      .rsp_digest_word, .rsp_word_index, .rsp_last_word
   );

endmodule

`default_nettype wire

// ----- hw/rtl/sha_checker.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher checker
// Port-level properties of the digest response sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_digest_word,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_last_word
);

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last_word does not match word_index");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word) |=>
         (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest words not delivered back to back");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_digest_word)))
      else $error("stalled response changed");

endmodule

bind sha256_stream_hasher_top sha_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_digest_word, .rsp_word_index,
   .rsp_last_word
);

`default_nettype wire
